// ===== rtl/sorted_insert_stack_assert.svh =====
// assertion macros for the sorted insert stack
`ifndef SORTED_INSERT_STACK_ASSERT_SVH
`define SORTED_INSERT_STACK_ASSERT_SVH

`ifndef SYNTH
`define SIS_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SIS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SIS_CHECK(lbl, expr, msg)
`define SIS_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/sis_pkg.sv =====
// shared types and constants of the sorted insert stack
package sis_pkg;

	localparam int DEPTH   = 16;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COUNT_W = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 72;

	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_PEEK = 2'd2
	} mode_t;

	typedef struct packed {
		logic                     push;
		logic                     pop;
		logic signed [DATA_W-1:0] value;
	} cell_ctrl_t;

endpackage

// ===== rtl/sis_cell.sv =====
// one slot of the sorted chain: holds a value, shifts down on push, up on pop
module sis_cell (
	input  logic                              clk,
	input  sis_pkg::cell_ctrl_t               ctrl,
	input  logic                              occ,
	input  logic                              prev_ge,
	input  logic signed [sis_pkg::DATA_W-1:0] prev_val,
	input  logic signed [sis_pkg::DATA_W-1:0] next_val,
	output logic                              ge,
	output logic signed [sis_pkg::DATA_W-1:0] val,
	output logic signed [sis_pkg::DATA_W-1:0] nxt
);
	import sis_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	// stored value stays above a new equal value
	assign ge  = occ && (val_q >= ctrl.value);
	assign val = val_q;

	always_comb begin
		nxt = val_q;
		if (ctrl.push) begin
			if (ge) begin
				nxt = val_q;
			end else if (prev_ge) begin
				nxt = ctrl.value;
			end else begin
				nxt = prev_val;
			end
		end else if (ctrl.pop) begin
			nxt = next_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.pop) begin
			val_q <= nxt;
		end
	end

endmodule

// ===== rtl/sorted_insert_stack.sv =====
// top level of the sorted insert stack: chain of slots, fill count, result register
//
// Bounded max-priority queue of DEPTH signed 32-bit values, kept in descending order
// in a chain of slots with the largest on top. Each input item carries an operation
// in s_tuser (push, pop, peek) and a value in s_tdata. The block takes one item
// per clock cycle and presents its result in the cycle after acceptance; it keeps that
// rate as long as the result side takes items. Every slot compares its own value
// with the broadcast push value and all slots update in the same cycle, so a push
// or pop shifts the whole chain at once whatever the fill. Popping or peeking an
// empty stack, or pushing into a full one, flags error and leaves the contents alone.
// No clearing pass runs after reset; only fill count and output valid are cleared.
`include "sorted_insert_stack_assert.svh"

module sorted_insert_stack (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// value[31:0]
	input  logic [sis_pkg::IN_TDATA_W-1:0]      s_tdata,
	// mode[1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// taken_value[31:0], top_value[63:32], count[68:64], is_empty[69], error[70]
	output logic [sis_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import sis_pkg::*;

	logic                     acc;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         cnt_d;
	logic                     full;
	logic                     empty;
	logic                     do_push;
	logic                     do_pop;
	logic                     err_d;
	logic signed [DATA_W-1:0] taken_d;
	logic signed [DATA_W-1:0] top_d;
	cell_ctrl_t               ctrl;
	mode_t                    mode;

	logic signed [DATA_W-1:0] val  [DEPTH];
	logic signed [DATA_W-1:0] nxt  [DEPTH];
	logic                     ge   [DEPTH];

	logic                     m_tvalid_q;
	logic signed [DATA_W-1:0] taken_q;
	logic signed [DATA_W-1:0] top_q;
	logic [COUNT_W-1:0]       count_out_q;
	logic                     empty_q;
	logic                     err_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign acc      = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign mode     = mode_t'(s_tuser);

	always_comb begin
		do_push = 1'b0;
		do_pop  = 1'b0;
		err_d   = 1'b0;
		taken_d = '0;
		cnt_d   = count_q;
		unique case (mode)
			MODE_PUSH: begin
				if (full) begin
					err_d = 1'b1;
				end else begin
					do_push = acc;
					cnt_d   = count_q + 1'b1;
				end
			end
			MODE_POP: begin
				if (empty) begin
					err_d = 1'b1;
				end else begin
					do_pop  = acc;
					taken_d = val[0];
					cnt_d   = count_q - 1'b1;
				end
			end
			MODE_PEEK: begin
				if (empty) begin
					err_d = 1'b1;
				end else begin
					taken_d = val[0];
				end
			end
			default: begin
				err_d = 1'b0;
			end
		endcase
	end

	assign ctrl.push  = do_push;
	assign ctrl.pop   = do_pop;
	assign ctrl.value = s_tdata[DATA_W-1:0];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                     pge;
			logic signed [DATA_W-1:0] pval;
			logic signed [DATA_W-1:0] nval;

			if (i == 0) begin : g_head
				assign pge  = 1'b1;
				assign pval = '0;
			end else begin : g_body
				assign pge  = ge[i-1];
				assign pval = val[i-1];
			end

			if (i == DEPTH - 1) begin : g_tail
				assign nval = '0;
			end else begin : g_mid
				assign nval = val[i+1];
			end

			sis_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.occ      (CNT_W'(i) < count_q),
				.prev_ge  (pge),
				.prev_val (pval),
				.next_val (nval),
				.ge       (ge[i]),
				.val      (val[i]),
				.nxt      (nxt[i])
			);
		end
	endgenerate

	assign top_d = (cnt_d == '0) ? '0 : nxt[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= cnt_d;
			end
			if (s_tready) begin
				m_tvalid_q <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			taken_q     <= taken_d;
			top_q       <= top_d;
			count_out_q <= COUNT_W'(cnt_d);
			empty_q     <= (cnt_d == '0);
			err_q       <= err_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, err_q, empty_q, count_out_q, top_q, taken_q};

	`SIS_CHECK(a_count_bound, count_q <= CNT_W'(DEPTH), "fill count above depth")
	`SIS_CHECK_NEXT(a_push_count, acc && do_push, count_q == $past(count_q) + 1'b1, "push count")
	`SIS_CHECK_NEXT(a_err_hold, acc && err_d, count_q == $past(count_q), "error changed count")

	generate
		for (i = 0; i < DEPTH - 1; i++) begin : g_chk
			`SIS_CHECK(a_sorted, !(CNT_W'(i + 1) < count_q) || (val[i] >= val[i+1]), "order broken")
		end
	endgenerate

endmodule

// ===== tb/sv/tb.sv =====
// testbench for sorted_insert_stack: random push, pop and peek traffic checked against a sorted queue
module tb;
	import sis_pkg::*;

	localparam logic [1:0] MODE_NONE  = 2'd3;
	localparam int         IDLE_LIMIT = 4000;
	localparam int         RANDOM_OPS = 850;

	typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} traffic_phase_t;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] value;
	} stack_op_t;

	typedef struct {
		logic [31:0] taken;
		logic [31:0] top;
		logic [4:0]  count;
		logic        empty;
		logic        err;
	} stack_result_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// value[31:0]
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	// mode[1:0]
	logic [1:0]             s_tuser  = MODE_PUSH;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// taken_value[31:0], top_value[63:32], count[68:64], is_empty[69], error[70]
	logic [OUT_TDATA_W-1:0] m_tdata;

	stack_op_t               pending_ops[$];
	stack_result_t           expected_results[$];
	logic signed [31:0]      stack_model[$];

	int burst_left = 10;
	int gap_left   = 0;
	int ready_style = 0;
	logic [5:0] stall_tick = '0;
	int idle_cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int n_push = 0, n_pop = 0, n_peek = 0, n_none = 0;
	int n_full_reject = 0, n_empty_reject = 0, deepest = 0;

	sorted_insert_stack u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic void add_op(logic [1:0] mode, logic [31:0] value);
		stack_op_t op;
		op.mode  = mode;
		op.value = value;
		pending_ops.push_back(op);
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: v = 32'($signed($urandom_range(0, 6)) - 3);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] pick_mode(traffic_phase_t phase);
		int r;
		int push_pct, pop_pct, peek_pct;
		r = $urandom_range(0, 99);
		case (phase)
			FILL_PHASE:  begin push_pct = 75; pop_pct = 15; peek_pct = 7; end
			DRAIN_PHASE: begin push_pct = 15; pop_pct = 70; peek_pct = 12; end
			default:     begin push_pct = 40; pop_pct = 40; peek_pct = 15; end
		endcase
		if (r < push_pct)
			return MODE_PUSH;
		else if (r < push_pct + pop_pct)
			return MODE_POP;
		else if (r < push_pct + pop_pct + peek_pct)
			return MODE_PEEK;
		return MODE_NONE;
	endfunction

	// sorted queue of stored values, largest first, equal values in arrival order
	function automatic void predict_stack_op(logic [1:0] mode, logic [31:0] value);
		stack_result_t res;
		logic signed [31:0] v;
		int pos;
		v = value;
		res.taken = '0;
		res.err   = 1'b0;
		case (mode)
			MODE_PUSH: begin
				n_push++;
				if (stack_model.size() >= DEPTH) begin
					res.err = 1'b1;
					n_full_reject++;
				end else begin
					pos = 0;
					while (pos < stack_model.size() && stack_model[pos] >= v)
						pos++;
					stack_model.insert(pos, v);
				end
			end
			MODE_POP: begin
				n_pop++;
				if (stack_model.size() == 0) begin
					res.err = 1'b1;
					n_empty_reject++;
				end else begin
					res.taken = stack_model.pop_front();
				end
			end
			MODE_PEEK: begin
				n_peek++;
				if (stack_model.size() == 0) begin
					res.err = 1'b1;
					n_empty_reject++;
				end else begin
					res.taken = stack_model[0];
				end
			end
			default: n_none++;
		endcase
		if (stack_model.size() > deepest)
			deepest = stack_model.size();
		res.top   = (stack_model.size() == 0) ? 32'd0 : stack_model[0];
		res.count = 5'(stack_model.size());
		res.empty = (stack_model.size() == 0);
		expected_results.push_back(res);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in %s at result %0d: expected %h, got %h",
					name, results_seen, want, got);
		end
	endfunction

	// sender: bursts of items separated by random gaps
	always @(posedge clk) begin
		stack_op_t next_op;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_stack_op(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || pending_ops.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					next_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= next_op.mode;
					s_tdata  <= next_op.value;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
							: $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// receiver: stall style changes each time the 6-bit stall counter wraps
	always @(posedge clk) begin
		logic ready_next;
		if (arst_n) begin
			stall_tick <= stall_tick + 6'd1;
			if (stall_tick == 6'd0)
				ready_style = $urandom_range(0, 4);
			case (ready_style)
				0: ready_next = 1'b1;
				1: ready_next = 1'($urandom_range(0, 1));
				2: ready_next = ($urandom_range(0, 3) == 0);
				3: ready_next = (stall_tick[2:0] != 3'd5) && (stall_tick[2:0] != 3'd6);
				default: ready_next = (stall_tick[5:3] != 3'd2);
			endcase
			m_tready <= ready_next;
		end
	end

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h with nothing pending", m_tdata);
			end else begin
				want = expected_results.pop_front();
				check_field("taken_value", want.taken, m_tdata[31:0]);
				check_field("top_value", want.top, m_tdata[63:32]);
				check_field("count", 32'(want.count), 32'(m_tdata[68:64]));
				check_field("is_empty", 32'(want.empty), 32'(m_tdata[69]));
				check_field("error", 32'(want.err), 32'(m_tdata[70]));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no progress for %0d cycles, %0d results still pending",
					IDLE_LIMIT, expected_results.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		traffic_phase_t phase;
		int random_ops;
		int phase_len;

		// empty store rejects, unused mode, extremes, duplicates, drain past empty
		add_op(MODE_POP,  32'hAAAA_AAAA);
		add_op(MODE_PEEK, 32'h5555_5555);
		add_op(MODE_NONE, 32'hFFFF_FFFF);
		add_op(MODE_PUSH, 32'h7FFF_FFFF);
		add_op(MODE_PUSH, 32'h8000_0000);
		add_op(MODE_PUSH, 32'h0000_0000);
		add_op(MODE_PUSH, 32'hFFFF_FFFF);
		add_op(MODE_PUSH, 32'h7FFF_FFFF);
		add_op(MODE_PEEK, 32'h0000_0000);
		add_op(MODE_NONE, 32'h1234_5678);
		add_op(MODE_POP,  32'h5555_5555);
		add_op(MODE_POP,  32'hAAAA_AAAA);
		add_op(MODE_PUSH, 32'h0000_0001);
		add_op(MODE_PUSH, 32'h0000_0000);
		add_op(MODE_POP,  32'h0000_0000);
		add_op(MODE_POP,  32'h0000_0000);
		add_op(MODE_POP,  32'h0000_0000);
		add_op(MODE_POP,  32'h0000_0000);
		add_op(MODE_POP,  32'h0000_0000);
		add_op(MODE_POP,  32'hFFFF_FFFF);
		add_op(MODE_PEEK, 32'hFFFF_FFFF);

		random_ops = 0;
		while (random_ops < RANDOM_OPS) begin
			case ($urandom_range(0, 2))
				0: phase = FILL_PHASE;
				1: phase = DRAIN_PHASE;
				default: phase = MIXED_PHASE;
			endcase
			phase_len = $urandom_range(8, 40);
			for (int i = 0; i < phase_len; i++) begin
				add_op(pick_mode(phase), pick_value());
				random_ops++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d operations: %0d push, %0d pop, %0d peek, %0d unused mode",
			n_push + n_pop + n_peek + n_none, n_push, n_pop, n_peek, n_none);
		$display("%0d rejected pushes on full, %0d rejected reads on empty, deepest fill %0d",
			n_full_reject, n_empty_reject, deepest);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
